### sv/hsb_pkg.sv
// Package for the HMAC-SHA1 base64 signer: shared widths, SHA-1 constants
// and the base64 alphabet function. No dependencies.
package hsb_pkg;

   localparam int CSR_IDX_W = 4;
   localparam int KEY_REGS  = 8;

   localparam logic [7:0] IPAD_BYTE  = 8'h36;
   localparam logic [7:0] OPAD_BYTE  = 8'h5C;
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [5:0] LEN_FIELD_AT = 6'd56;
   localparam logic [63:0] OUTER_BITS = 64'd672;   // 84 bytes times 8
   localparam logic [5:0] TAG_BYTES_LAST = 6'd19;
   localparam logic [4:0] OUT_CHARS_LAST = 5'd27;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // Status of the compression core as seen by the sequencer.
   typedef struct packed {
      logic         busy;
      logic [5:0]   fill;
      logic [159:0] chain;
   } core_stat_type;

   // Byte push and chain reload requests to the compression core.
   typedef struct packed {
      logic       load_iv;
      logic       push;
      logic [7:0] data;
   } core_ctrl_type;

   // Standard base64 alphabet.
   function automatic logic [7:0] b64_char_of(input logic [5:0] idx);
      logic [7:0] c;
      if (idx < 6'd26)      c = 8'h41 + {2'b00, idx};
      else if (idx < 6'd52) c = 8'h61 + {2'b00, idx} - 8'd26;
      else if (idx < 6'd62) c = 8'h30 + {2'b00, idx} - 8'd52;
      else if (idx == 6'd62) c = 8'h2B;
      else                  c = 8'h2F;
      return c;
   endfunction

endpackage

### sv/hsb_if.sv
// Handshake interfaces for the signer: message, result and register write words.
// Uses hsb_pkg for the register index width.
interface hsb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       last_byte;
   modport source (output valid, msg_byte, last_byte, input ready);
   modport sink   (input valid, msg_byte, last_byte, output ready);
endinterface

interface hsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] b64_char;
   logic       last_char;
   logic       too_long;
   modport source (output valid, b64_char, last_char, too_long, input ready);
   modport sink   (input valid, b64_char, last_char, too_long, output ready);
endinterface

interface hsb_csr_if import hsb_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [63:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/hsb_core.sv
// SHA-1 compression core: byte packing, 16-word schedule shift line and one
// round unit reused for 80 rounds, plus the chain words. Uses hsb_pkg.
module hsb_core import hsb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   output core_stat_type stat
);

   logic [5:0]  fill_ff, fill_in;
   logic [23:0] acc_ff, acc_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [6:0]  rnd_ff, rnd_in;
   logic        run_ff, run_in, add_ff, add_in;
   logic [31:0] wt, f, k, sched;

   // Round function and schedule word for the current round.
   always_comb begin
      sched = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wt = (rnd_ff < 7'd16) ? w_ff[0] : {sched[30:0], sched[31]};
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
   end

   // Next state: byte packing, rounds, and the final chain update.
   always_comb begin
      fill_in = fill_ff;
      acc_in  = acc_ff;
      w_in    = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in    = h_ff;
      rnd_in  = rnd_ff;
      run_in  = run_ff;
      add_in  = 1'b0;
      if (ctrl.load_iv) begin
         h_in[0] = IV0; h_in[1] = IV1; h_in[2] = IV2; h_in[3] = IV3; h_in[4] = IV4;
         fill_in = '0;
      end
      if (ctrl.push) begin
         acc_in  = {acc_ff[15:0], ctrl.data};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = {acc_ff, ctrl.data};
         end
         if (fill_ff == 6'd63) begin
            run_in = 1'b1;
            rnd_in = '0;
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
         end
      end
      if (run_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wt;
         a_in = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wt;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end
      if (add_ff) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
   end

   // Control state and chain words take reset; the data path does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rnd_ff  <= '0;
         run_ff  <= 1'b0;
         add_ff  <= 1'b0;
         h_ff[0] <= IV0; h_ff[1] <= IV1; h_ff[2] <= IV2; h_ff[3] <= IV3; h_ff[4] <= IV4;
      end else begin
         fill_ff <= fill_in;
         rnd_ff  <= rnd_in;
         run_ff  <= run_in;
         add_ff  <= add_in;
         h_ff    <= h_in;
      end
      acc_ff <= acc_in;
      w_ff   <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end

   assign stat.busy  = run_ff | add_ff;
   assign stat.fill  = fill_ff;
   assign stat.chain = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};

endmodule

### sv/hsb_b64.sv
// Base64 encoder and output register for the 20-byte tag, one character a word.
// Uses hsb_pkg and the result interface.
module hsb_b64 import hsb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [159:0]  tag,
   input  logic          ovf,
   output logic          busy,
   hsb_rsp_if.source     rsp_ch
);

   logic [167:0] sh_ff, sh_in;
   logic [4:0]   idx_ff, idx_in;
   logic         act_ff, act_in;
   logic         vld_ff, vld_in;
   logic [7:0]   chr_ff, chr_in;
   logic         lst_ff, lst_in;
   logic         tl_ff, tl_in;
   logic         emit;

   // A character moves into the output register when it is empty or drained.
   always_comb begin
      emit   = act_ff && (!vld_ff || rsp_ch.ready);
      sh_in  = sh_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      vld_in = vld_ff && !rsp_ch.ready;
      chr_in = chr_ff;
      lst_in = lst_ff;
      tl_in  = tl_ff;
      if (start) begin
         sh_in  = {tag, 8'h00};
         idx_in = '0;
         act_in = 1'b1;
      end else if (emit) begin
         chr_in = (idx_ff == OUT_CHARS_LAST) ? PAD_CHAR : b64_char_of(sh_ff[167:162]);
         lst_in = (idx_ff == OUT_CHARS_LAST);
         tl_in  = ovf;
         vld_in = 1'b1;
         sh_in  = {sh_ff[161:0], 6'b0};
         idx_in = idx_ff + 5'd1;
         if (idx_ff == OUT_CHARS_LAST) act_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         act_ff <= act_in;
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
      sh_ff  <= sh_in;
      chr_ff <= chr_in;
      lst_ff <= lst_in;
      tl_ff  <= tl_in;
   end

   assign busy             = act_ff | vld_ff;
   assign rsp_ch.valid     = vld_ff;
   assign rsp_ch.b64_char  = chr_ff;
   assign rsp_ch.last_char = lst_ff;
   assign rsp_ch.too_long  = tl_ff;

endmodule

### sv/hmac_sha1_base64_signer.sv
// HMAC-SHA1 signer: one message byte per input word, 28 base64 characters per tag.
// Each message byte is pushed into the compression core, which runs its rounds when a 64-byte block fills.
// The first byte of a message first loads the inner pad block, which is then compressed.
// The final byte adds padding, the outer hash (two blocks) and the 28 output characters.
// Throughput is set by the single round unit, shared by every block; byte input waits while it is busy.
// Synchronous active-high reset clears the key registers and the sequencer and loads the SHA-1 IV into the chain.
module hmac_sha1_base64_signer import hsb_pkg::*; #(
   parameter int LEN_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   hsb_req_if.sink   req_ch,
   hsb_rsp_if.source rsp_ch,
   hsb_csr_if.sink   csr_ch
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_IPAD  = 10'b0000000010,
      S_MSG   = 10'b0000000100,
      S_P80   = 10'b0000001000,
      S_PZERO = 10'b0000010000,
      S_PLEN  = 10'b0000100000,
      S_WAITH = 10'b0001000000,
      S_OPAD  = 10'b0010000000,
      S_IDIG  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type            st_ff, st_in;
   logic [63:0]          key_ff [KEY_REGS];
   logic [5:0]           cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 phase_ff, phase_in;
   logic                 outer_ff, outer_in;
   logic [7:0]           byte_ff;
   logic                 last_ff;
   logic [63:0]          len_ff, len_in;
   logic [159:0]         dig_ff, dig_in;
   logic [LEN_BITS:0]    total;
   logic [7:0]           key_byte;
   logic                 b64_start, b64_busy;
   core_ctrl_type        ctrl;
   core_stat_type        stat;

   // Register writes; indexes past the key registers are ignored.
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REGS; i++) key_ff[i] <= '0;
      end else if (csr_ch.valid && csr_ch.index < CSR_IDX_W'(KEY_REGS)) begin
         key_ff[csr_ch.index[2:0]] <= csr_ch.data;
      end
   end

   assign req_ch.ready = (st_ff == S_IDLE);
   assign key_byte     = key_ff[cnt_ff[5:3]][8*(7-cnt_ff[2:0]) +: 8];
   assign total        = {1'b0, count_ff} + (LEN_BITS+1)'(64);

   // Sequencer: feeds one byte a cycle into the core whenever it is free, but only one per input word in S_MSG.
   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      phase_in  = phase_ff;
      outer_in  = outer_ff;
      len_in    = len_ff;
      dig_in    = dig_ff;
      ctrl      = '0;
      b64_start = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (!phase_ff) begin
                  ctrl.load_iv = 1'b1;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  cnt_in   = '0;
                  st_in    = S_IPAD;
               end else begin
                  st_in = S_MSG;
               end
            end
         end
         S_IPAD, S_OPAD: begin
            if (!stat.busy) begin
               ctrl.push = 1'b1;
               ctrl.data = key_byte ^ ((st_ff == S_IPAD) ? IPAD_BYTE : OPAD_BYTE);
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  cnt_in = '0;
                  if (st_ff == S_IPAD) begin
                     phase_in = 1'b1;
                     st_in = S_MSG;
                  end else begin
                     st_in = S_IDIG;
                  end
               end
            end
         end
         S_MSG: begin
            if (!stat.busy) begin
               ctrl.push = 1'b1;
               ctrl.data = byte_ff;
               count_in  = count_ff + LEN_BITS'(1);
               if (count_in == '0) ovf_in = 1'b1;
               st_in = last_ff ? S_P80 : S_IDLE;
            end
         end
         S_IDIG: begin
            if (!stat.busy) begin
               ctrl.push = 1'b1;
               ctrl.data = dig_ff[159:152];
               dig_in = {dig_ff[151:0], 8'h00};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == TAG_BYTES_LAST) st_in = S_P80;
            end
         end
         S_P80: begin
            if (!stat.busy) begin
               ctrl.push = 1'b1;
               ctrl.data = PAD_MARK;
               len_in = outer_ff ? OUTER_BITS : (64'(total) << 3);
               st_in = S_PZERO;
            end
         end
         S_PZERO: begin
            if (!stat.busy) begin
               if (stat.fill == LEN_FIELD_AT) begin
                  cnt_in = '0;
                  st_in  = S_PLEN;
               end else begin
                  ctrl.push = 1'b1;
                  ctrl.data = 8'h00;
               end
            end
         end
         S_PLEN: begin
            if (!stat.busy) begin
               ctrl.push = 1'b1;
               ctrl.data = len_ff[63:56];
               len_in = {len_ff[55:0], 8'h00};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd7) st_in = S_WAITH;
            end
         end
         S_WAITH: begin
            if (!stat.busy) begin
               if (!outer_ff) begin
                  dig_in       = stat.chain;
                  ctrl.load_iv = 1'b1;
                  outer_in     = 1'b1;
                  cnt_in       = '0;
                  st_in        = S_OPAD;
               end else begin
                  b64_start = 1'b1;
                  st_in     = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!b64_busy) begin
               ctrl.load_iv = 1'b1;
               phase_in = 1'b0;
               outer_in = 1'b0;
               count_in = '0;
               ovf_in   = 1'b0;
               st_in    = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         cnt_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         phase_ff <= 1'b0;
         outer_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         phase_ff <= phase_in;
         outer_ff <= outer_in;
      end
      len_ff <= len_in;
      dig_ff <= dig_in;
      if (req_ch.valid && req_ch.ready) begin
         byte_ff <= req_ch.msg_byte;
         last_ff <= req_ch.last_byte;
      end
   end

   hsb_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   hsb_b64 u_b64 (
      .clock  (clock),
      .reset  (reset),
      .start  (b64_start),
      .tag    (stat.chain),
      .ovf    (ovf_ff),
      .busy   (b64_busy),
      .rsp_ch (rsp_ch)
   );

endmodule

### sv/hsb_checker.sv
// Port-level checks for the signer and the bind that attaches them.
// Depends on hmac_sha1_base64_signer and its interface ports.
module hsb_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last,
   input logic [7:0] rsp_char
);

   // A pending result word holds its character until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char))
      else $error("result word changed while stalled");

   // No message word is taken while tag characters are still going out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during tag output");

   // The final character ends the tag: nothing follows in the next cycle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("character after final tag character");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hmac_sha1_base64_signer hsb_checker u_hsb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last_char),
   .rsp_char  (rsp_ch.b64_char)
);
